### hw/rtl/gqv_pkg.sv
// ----------------------------------------------------------------------------
// gqv_pkg
// Shared types, constants and helpers of the glyph quad vertex generator.
// ----------------------------------------------------------------------------
package gqv_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int GLYPH_AW      = $clog2(GLYPH_ENTRIES);
  localparam int KERN_ENTRIES  = 64;
  localparam int KERN_AW       = $clog2(KERN_ENTRIES);
  localparam int KCNT_W        = $clog2(KERN_ENTRIES + 1);

  localparam logic [1:0] OP_CHAR       = 2'd0;
  localparam logic [1:0] OP_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] OP_LOAD_KERN  = 2'd2;
  localparam logic [1:0] OP_NEW_STRING = 2'd3;

  localparam logic CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [15:0]        u1;
    logic [15:0]        v1;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
    logic signed [15:0] advance;
    logic [7:0]         page;
  } glyph_t;

  typedef struct packed {
    logic [7:0]         first;
    logic [7:0]         second;
    logic signed [15:0] amount;
  } kern_t;

  typedef struct packed {
    logic signed [23:0] xl;
    logic signed [23:0] xr;
    logic signed [17:0] yb;
    logic [15:0]        u0;
    logic [15:0]        v0;
    logic [15:0]        u1;
    logic [15:0]        v1;
    logic [7:0]         page;
    logic               have_prev;
  } job_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

### hw/rtl/gqv_div.sv
// ----------------------------------------------------------------------------
// gqv_div
// Restoring divider that forms a rounded, saturated Q0.16 texture coordinate.
// ----------------------------------------------------------------------------
module gqv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] num2,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot
);
  import gqv_pkg::*;

  logic        busy_r;
  logic [5:0]  step_r;
  logic [33:0] num_r;
  logic [33:0] q_r;
  logic [17:0] rem_r;
  logic [16:0] dvs_r;
  logic        zero_r;
  logic        done_r;
  logic [17:0] trial;
  logic        fits;

  assign trial = {rem_r[16:0], num_r[33]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 6'd0;
        num_r  <= {1'b0, num2, 16'd0} + {18'd0, den};
        q_r    <= '0;
        rem_r  <= '0;
        dvs_r  <= {den, 1'b0};
        zero_r <= den == 16'd0;
      end else if (busy_r) begin
        num_r <= {num_r[32:0], 1'b0};
        q_r   <= {q_r[32:0], fits};
        rem_r <= fits ? trial - {1'b0, dvs_r} : trial;
        step_r <= step_r + 6'd1;
        if (step_r == 6'd33) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (zero_r || q_r[33:16] != 18'd0) ? 16'hFFFF : q_r[15:0];

endmodule

### hw/rtl/gqv_front.sv
// ----------------------------------------------------------------------------
// gqv_front
// Accepts requests, runs glyph and kerning loads, and turns characters into
// quad jobs with the pen position resolved.
// ----------------------------------------------------------------------------
module gqv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_code,
  input  logic [15:0]         in_tex_x,
  input  logic [15:0]         in_tex_y,
  input  logic [15:0]         in_glyph_width,
  input  logic [15:0]         in_glyph_height,
  input  logic signed [15:0]  in_offset_x,
  input  logic signed [15:0]  in_offset_y,
  input  logic signed [15:0]  in_advance,
  input  logic [7:0]          in_page,
  input  logic [7:0]          in_second_code,
  input  logic signed [15:0]  in_kern_amount,
  output logic                push,
  output gqv_pkg::job_t       push_job,
  input  logic                full
);
  import gqv_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DGO  = 3'd1;
  localparam logic [2:0] ST_DWT  = 3'd2;
  localparam logic [2:0] ST_GWR  = 3'd3;
  localparam logic [2:0] ST_KRD  = 3'd4;
  localparam logic [2:0] ST_KCMP = 3'd5;
  localparam logic [2:0] ST_CFIN = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] aw_r, ah_r;

  logic [7:0]         code_r;
  logic [15:0]        tx_r, ty_r, w_r, h_r;
  logic signed [15:0] offx_r, offy_r, adv_r;
  logic [7:0]         page_r;

  logic [1:0]  gsel_r;
  logic [15:0] q_r [4];

  glyph_t gmem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] gvld_r;
  glyph_t grd_r;
  logic   grd_vld_r;
  glyph_t gly;

  kern_t kmem [KERN_ENTRIES];
  kern_t krd_r;
  logic [KCNT_W-1:0]  kcnt_r;
  logic [KERN_AW-1:0] kidx_r;
  logic signed [15:0] kern_r;

  logic signed [23:0] pen_r;
  logic [7:0]         prev_code_r;
  logic               have_prev_r;

  logic        accept;
  logic        div_start, div_done;
  logic [16:0] div_num;
  logic [15:0] div_den, div_q;
  glyph_t      gwr;
  logic        kmatch, klast;
  logic signed [23:0] pen_k, xr, pen_a;

  assign in_ready = state_r == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (gsel_r)
      2'd0: begin
        div_num = {tx_r, 1'b1};
        div_den = aw_r;
      end
      2'd1: begin
        div_num = {w_r, 1'b0};
        div_den = aw_r;
      end
      2'd2: begin
        div_num = {ty_r, 1'b1};
        div_den = ah_r;
      end
      default: begin
        div_num = {h_r, 1'b0};
        div_den = ah_r;
      end
    endcase
  end

  assign div_start = state_r == ST_DGO;

  gqv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num2  (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    gwr.u0      = q_r[0];
    gwr.v0      = q_r[2];
    gwr.u1      = sat_add16(q_r[0], q_r[1]);
    gwr.v1      = sat_add16(q_r[2], q_r[3]);
    gwr.right   = {{2{offx_r[15]}}, offx_r} + {2'b00, w_r};
    gwr.bottom  = {{2{offy_r[15]}}, offy_r} + {2'b00, h_r};
    gwr.advance = adv_r;
    gwr.page    = page_r;
  end

  assign gly    = grd_vld_r ? grd_r : '0;
  assign kmatch = krd_r.first == prev_code_r && krd_r.second == code_r;
  assign klast  = ({1'b0, kidx_r} + KCNT_W'(1)) == kcnt_r;
  assign pen_k  = sat24({pen_r[23], pen_r} + {{9{kern_r[15]}}, kern_r});
  assign xr     = sat24({pen_k[23], pen_k} + {{7{gly.right[17]}}, gly.right});
  assign pen_a  = sat24({pen_k[23], pen_k} + {{9{gly.advance[15]}}, gly.advance});

  assign push = state_r == ST_CFIN && !full;
  always_comb begin
    push_job.xl        = pen_k;
    push_job.xr        = xr;
    push_job.yb        = -gly.bottom;
    push_job.u0        = gly.u0;
    push_job.v0        = gly.v0;
    push_job.u1        = gly.u1;
    push_job.v1        = gly.v1;
    push_job.page      = gly.page;
    push_job.have_prev = have_prev_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_LOAD_GLYPH: state_nxt = ST_DGO;
            OP_CHAR:       state_nxt = (kcnt_r != '0) ? ST_KRD : ST_CFIN;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DGO: state_nxt = ST_DWT;
      ST_DWT: begin
        if (div_done) begin
          state_nxt = (gsel_r == 2'd3) ? ST_GWR : ST_DGO;
        end
      end
      ST_GWR: state_nxt = ST_IDLE;
      ST_KRD: state_nxt = ST_KCMP;
      ST_KCMP: begin
        if (kmatch || klast) begin
          state_nxt = ST_CFIN;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_CFIN: begin
        if (!full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      aw_r        <= 16'd256;
      ah_r        <= 16'd256;
      gvld_r      <= '0;
      kcnt_r      <= '0;
      pen_r       <= '0;
      prev_code_r <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATLAS_WIDTH:  aw_r <= cfg_data;
          CFG_ATLAS_HEIGHT: ah_r <= cfg_data;
          default:          aw_r <= aw_r;
        endcase
      end
      if (accept) begin
        code_r <= in_code;
        tx_r   <= in_tex_x;
        ty_r   <= in_tex_y;
        w_r    <= in_glyph_width;
        h_r    <= in_glyph_height;
        offx_r <= in_offset_x;
        offy_r <= in_offset_y;
        adv_r  <= in_advance;
        page_r <= in_page;
        gsel_r <= 2'd0;
        kidx_r <= '0;
        kern_r <= '0;
        grd_vld_r <= gvld_r[in_code[GLYPH_AW-1:0]];
        if (in_operation == OP_LOAD_KERN && kcnt_r < KCNT_W'(KERN_ENTRIES)) begin
          kcnt_r <= kcnt_r + KCNT_W'(1);
        end
        if (in_operation == OP_NEW_STRING) begin
          pen_r       <= '0;
          prev_code_r <= '0;
          have_prev_r <= 1'b0;
        end
      end
      if (state_r == ST_DWT && div_done) begin
        q_r[gsel_r] <= div_q;
        gsel_r      <= gsel_r + 2'd1;
      end
      if (state_r == ST_GWR) begin
        gvld_r[code_r[GLYPH_AW-1:0]] <= 1'b1;
      end
      if (state_r == ST_KCMP) begin
        if (kmatch) begin
          kern_r <= krd_r.amount;
        end else if (!klast) begin
          kidx_r <= kidx_r + KERN_AW'(1);
        end
      end
      if (push) begin
        pen_r       <= pen_a;
        prev_code_r <= code_r;
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GWR) begin
      gmem[code_r[GLYPH_AW-1:0]] <= gwr;
    end
    if (accept) begin
      grd_r <= gmem[in_code[GLYPH_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_LOAD_KERN && kcnt_r < KCNT_W'(KERN_ENTRIES)) begin
      kmem[kcnt_r[KERN_AW-1:0]] <= '{first: in_code, second: in_second_code,
                                     amount: in_kern_amount};
    end
    if (state_r == ST_KRD) begin
      krd_r <= kmem[kidx_r];
    end
  end

endmodule

### hw/rtl/gqv_fifo.sv
// ----------------------------------------------------------------------------
// gqv_fifo
// Two-entry queue of quad jobs between the front and back ends.
// ----------------------------------------------------------------------------
module gqv_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gqv_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gqv_pkg::job_t pop_job,
  output logic          empty
);
  import gqv_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= push_job;
        wp_r        <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/gqv_back.sv
// ----------------------------------------------------------------------------
// gqv_back
// Expands each quad job into its strip vertices through an output register.
// ----------------------------------------------------------------------------
module gqv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gqv_pkg::job_t       pop_job,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_pos_x,
  output logic signed [17:0]  out_pos_y,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic [7:0]          out_tex_page,
  output logic                out_last_of_run
);
  import gqv_pkg::*;

  job_t               job_r;
  logic               job_vld_r;
  logic [2:0]         step_r;
  logic               out_valid_r;
  logic signed [23:0] prev_x_r;
  logic signed [17:0] prev_y_r;
  logic [15:0]        prev_u_r, prev_v_r;
  logic [7:0]         prev_page_r;

  logic               emit;
  logic signed [23:0] vx;
  logic signed [17:0] vy;
  logic [15:0]        vu, vv;
  logic [7:0]         vp;

  assign pop       = !job_vld_r && !empty;
  assign emit      = job_vld_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    vx = job_r.xl;
    vy = '0;
    vu = job_r.u0;
    vv = job_r.v0;
    vp = job_r.page;
    unique case (step_r)
      3'd0: begin
        vx = prev_x_r;
        vy = prev_y_r;
        vu = prev_u_r;
        vv = prev_v_r;
        vp = prev_page_r;
      end
      3'd3: begin
        vy = job_r.yb;
        vv = job_r.v1;
      end
      3'd4: begin
        vx = job_r.xr;
        vu = job_r.u1;
      end
      3'd5: begin
        vx = job_r.xr;
        vy = job_r.yb;
        vu = job_r.u1;
        vv = job_r.v1;
      end
      default: vx = job_r.xl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r   <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_u_r    <= '0;
      prev_v_r    <= '0;
      prev_page_r <= '0;
    end else begin
      if (pop) begin
        job_r     <= pop_job;
        job_vld_r <= 1'b1;
        step_r    <= pop_job.have_prev ? 3'd0 : 3'd2;
      end
      if (emit) begin
        out_valid_r     <= 1'b1;
        out_pos_x       <= vx;
        out_pos_y       <= vy;
        out_tex_u       <= vu;
        out_tex_v       <= vv;
        out_tex_page    <= vp;
        out_last_of_run <= step_r == 3'd5;
        if (step_r == 3'd5) begin
          job_vld_r   <= 1'b0;
          prev_x_r    <= job_r.xr;
          prev_y_r    <= job_r.yb;
          prev_u_r    <= job_r.u1;
          prev_v_r    <= job_r.v1;
          prev_page_r <= job_r.page;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/glyph_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator
// A character emits four vertices, or six after the first of a string, one
// per cycle while out_ready is held; the front end scans the kerning pairs
// and the back end emits the vertices, overlapped by the queue.
// A glyph load runs its four quotients through the shared divider.
// Synchronous active-low reset clears the tables' valid bits and all control.
// ----------------------------------------------------------------------------
module glyph_quad_vertex_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_code,
  input  logic [15:0]         in_tex_x,
  input  logic [15:0]         in_tex_y,
  input  logic [15:0]         in_glyph_width,
  input  logic [15:0]         in_glyph_height,
  input  logic signed [15:0]  in_offset_x,
  input  logic signed [15:0]  in_offset_y,
  input  logic signed [15:0]  in_advance,
  input  logic [7:0]          in_page,
  input  logic [7:0]          in_second_code,
  input  logic signed [15:0]  in_kern_amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_pos_x,
  output logic signed [17:0]  out_pos_y,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic [7:0]          out_tex_page,
  output logic                out_last_of_run
);
  import gqv_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  gqv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_code         (in_code),
    .in_tex_x        (in_tex_x),
    .in_tex_y        (in_tex_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_advance      (in_advance),
    .in_page         (in_page),
    .in_second_code  (in_second_code),
    .in_kern_amount  (in_kern_amount),
    .push            (push),
    .push_job        (push_job),
    .full            (full)
  );

  gqv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  gqv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_job         (pop_job),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_tex_page    (out_tex_page),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### hw/rtl/gqv_checker.sv
// ----------------------------------------------------------------------------
// gqv_checker
// Port-level checks of the glyph quad vertex generator, bound to the top.
// ----------------------------------------------------------------------------
module gqv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_operation,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [23:0]  out_pos_x,
  input logic signed [17:0]  out_pos_y,
  input logic [15:0]         out_tex_u,
  input logic [15:0]         out_tex_v,
  input logic [7:0]          out_tex_page,
  input logic                out_last_of_run
);
  import gqv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_tex_u) && $stable(out_tex_v) && $stable(out_tex_page)
      && $stable(out_last_of_run))
    else $error("Result request changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("Block not idle after reset.");

  a_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_LOAD_GLYPH |=> !in_ready)
    else $error("Glyph load did not hold off the next request.");

endmodule

bind glyph_quad_vertex_generator gqv_checker u_gqv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pos_x       (out_pos_x),
  .out_pos_y       (out_pos_y),
  .out_tex_u       (out_tex_u),
  .out_tex_v       (out_tex_v),
  .out_tex_page    (out_tex_page),
  .out_last_of_run (out_last_of_run)
);
